FILE: hdl/cwlc_pkg.sv
//------------------------------------------------------------------------------
// cwlc_pkg
// Shared constants for the convex window line clipper.
//------------------------------------------------------------------------------
package cwlc_pkg;

   localparam int NUM_EDGES    = 4;
   localparam int NUM_REGS     = 2 * NUM_EDGES;
   localparam int REG_IDX_BITS = 3;

   // corner registers: x0, y0, x1, y1, x2, y2, x3, y3
   localparam int CORNER_RESET [NUM_REGS] = '{100, 100, 100, 300, 300, 300, 300, 100};

endpackage

FILE: hdl/convex_window_line_clipper_core.sv
// Pipeline: four geometry stages, one divider stage per quotient bit, three
//   interpolation stages and the output buffer.
// Throughput: one request per cycle unless a full output buffer stalls the
//   pipeline; the divider pipeline sets the depth.
// Reset: the corner registers return to the default window and the pipeline
//   and the two-entry output buffer are emptied.
//------------------------------------------------------------------------------
// convex_window_line_clipper_core
// Clips a segment against a four-corner convex window held in registers.
//------------------------------------------------------------------------------
module convex_window_line_clipper_core #(
   parameter int COORD_BITS  = 12,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // clip_start_x, clip_start_y, clip_end_x, clip_end_y
   output logic [((4*COORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   // visible
   output logic                                    rsp_tuser,
   input  logic                                    csr_wr_en,
   input  logic [cwlc_pkg::REG_IDX_BITS-1:0]       csr_index,
   input  logic [COORD_BITS-1:0]                   csr_wdata
);
   import cwlc_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int MW = 2 * C + 2;
   localparam int QW = T_FRAC_BITS + 2;
   localparam int DW = ((4 * C + 7) / 8) * 8;
   localparam int PW = 4 * C + 2 + 3 * NUM_EDGES + 1;

   logic [C-1:0] corner_ff [NUM_REGS];
   logic [NUM_EDGES-1:0][C-1:0] cx, cy;

   logic en, f_valid, d_valid;
   logic [NUM_EDGES-1:0][MW-1:0] an, ad;
   logic [NUM_EDGES-1:0] f_neg, f_sat, f_ent, f_lev, d_neg, d_sat, d_ent, d_lev;
   logic f_rej, d_rej;
   logic [C-1:0] f_px, f_py, d_px, d_py;
   logic [C:0]   f_dx, f_dy, d_dx, d_dy;
   logic [PW-1:0] pay_i, pay_o;
   logic [NUM_EDGES-1:0][QW-1:0] quot;
   logic [4*C-1:0] coords;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            corner_ff[i] <= C'(CORNER_RESET[i]);
         end
      end else if (csr_wr_en) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            if (csr_index == REG_IDX_BITS'(i)) begin
               corner_ff[i] <= csr_wdata;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_EDGES; k++) begin
         cx[k] = corner_ff[2*k];
         cy[k] = corner_ff[2*k+1];
      end
   end

   assign req_tready = en;

   cwlc_front #(.COORD_BITS(C)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .start_x   (req_tdata[C-1:0]),
      .start_y   (req_tdata[2*C-1:C]),
      .end_x     (req_tdata[3*C-1:2*C]),
      .end_y     (req_tdata[4*C-1:3*C]),
      .corner_x  (cx),
      .corner_y  (cy),
      .out_valid (f_valid),
      .num_mag   (an),
      .den_mag   (ad),
      .neg       (f_neg),
      .sat       (f_sat),
      .entry     (f_ent),
      .leave     (f_lev),
      .rej       (f_rej),
      .px        (f_px),
      .py        (f_py),
      .dx        (f_dx),
      .dy        (f_dy)
   );

   assign pay_i = {f_rej, f_lev, f_ent, f_neg, f_dy, f_dx, f_py, f_px};

   cwlc_div #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS), .PAY_BITS(PW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .num_mag   (an),
      .den_mag   (ad),
      .sat_i     (f_sat),
      .pay_i     (pay_i),
      .out_valid (d_valid),
      .quot      (quot),
      .sat_o     (d_sat),
      .pay_o     (pay_o)
   );

   assign {d_rej, d_lev, d_ent, d_neg, d_dy, d_dx, d_py, d_px} = pay_o;

   cwlc_back #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid),
      .quot       (quot),
      .sat        (d_sat),
      .neg        (d_neg),
      .entry      (d_ent),
      .leave      (d_lev),
      .rej        (d_rej),
      .px         (d_px),
      .py         (d_py),
      .dx         (d_dx),
      .dy         (d_dy),
      .en         (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .visible    (rsp_tuser),
      .coords     (coords)
   );

   assign rsp_tdata = DW'(coords);

endmodule

FILE: hdl/cwlc_front.sv
//------------------------------------------------------------------------------
// cwlc_front
// Geometry front end: differences, dot products, magnitudes and edge flags.
// Four register stages.
//------------------------------------------------------------------------------
module cwlc_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              en,
   input  logic                                              in_valid,
   input  logic [COORD_BITS-1:0]                             start_x,
   input  logic [COORD_BITS-1:0]                             start_y,
   input  logic [COORD_BITS-1:0]                             end_x,
   input  logic [COORD_BITS-1:0]                             end_y,
   input  logic [cwlc_pkg::NUM_EDGES-1:0][COORD_BITS-1:0]    corner_x,
   input  logic [cwlc_pkg::NUM_EDGES-1:0][COORD_BITS-1:0]    corner_y,
   output logic                                              out_valid,
   output logic [cwlc_pkg::NUM_EDGES-1:0][2*COORD_BITS+1:0]  num_mag,
   output logic [cwlc_pkg::NUM_EDGES-1:0][2*COORD_BITS+1:0]  den_mag,
   output logic [cwlc_pkg::NUM_EDGES-1:0]                    neg,
   output logic [cwlc_pkg::NUM_EDGES-1:0]                    sat,
   output logic [cwlc_pkg::NUM_EDGES-1:0]                    entry,
   output logic [cwlc_pkg::NUM_EDGES-1:0]                    leave,
   output logic                                              rej,
   output logic [COORD_BITS-1:0]                             px,
   output logic [COORD_BITS-1:0]                             py,
   output logic [COORD_BITS:0]                               dx,
   output logic [COORD_BITS:0]                               dy
);
   import cwlc_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int PW = 2 * C + 2;
   localparam int SW = 2 * C + 3;
   localparam int MW = 2 * C + 2;

   logic [3:0] v_ff;

   // stage 1
   logic signed [C-1:0] px1_ff, py1_ff;
   logic signed [C:0]   dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic signed [C:0]   nx1_ff [NUM_EDGES];
   logic signed [C:0]   ny1_ff [NUM_EDGES];
   logic signed [C:0]   wx1_ff [NUM_EDGES];
   logic signed [C:0]   wy1_ff [NUM_EDGES];
   logic signed [C:0]   nx1_in [NUM_EDGES];
   logic signed [C:0]   ny1_in [NUM_EDGES];
   logic signed [C:0]   wx1_in [NUM_EDGES];
   logic signed [C:0]   wy1_in [NUM_EDGES];
   // stage 2
   logic signed [C-1:0]  px2_ff, py2_ff;
   logic signed [C:0]    dx2_ff, dy2_ff;
   logic signed [PW-1:0] mdx_ff [NUM_EDGES];
   logic signed [PW-1:0] mdy_ff [NUM_EDGES];
   logic signed [PW-1:0] mwx_ff [NUM_EDGES];
   logic signed [PW-1:0] mwy_ff [NUM_EDGES];
   // stage 3
   logic signed [C-1:0]  px3_ff, py3_ff;
   logic signed [C:0]    dx3_ff, dy3_ff;
   logic signed [SW-1:0] nd3_ff [NUM_EDGES];
   logic signed [SW-1:0] nw3_ff [NUM_EDGES];
   // stage 4
   logic [C-1:0] px4_ff, py4_ff;
   logic [C:0]   dx4_ff, dy4_ff;
   logic [NUM_EDGES-1:0][MW-1:0] an4_ff, ad4_ff, an4_in, ad4_in;
   logic [NUM_EDGES-1:0] neg4_ff, sat4_ff, ent4_ff, lev4_ff;
   logic [NUM_EDGES-1:0] neg4_in, sat4_in, ent4_in, lev4_in, par_rej;
   logic rej4_ff;

   always_comb begin
      int nk;
      dx1_in = (C+1)'($signed(end_x)) - (C+1)'($signed(start_x));
      dy1_in = (C+1)'($signed(end_y)) - (C+1)'($signed(start_y));
      for (int k = 0; k < NUM_EDGES; k++) begin
         nk = (k + 1) % NUM_EDGES;
         nx1_in[k] = (C+1)'($signed(corner_y[nk])) - (C+1)'($signed(corner_y[k]));
         ny1_in[k] = (C+1)'($signed(corner_x[k])) - (C+1)'($signed(corner_x[nk]));
         wx1_in[k] = (C+1)'($signed(start_x)) - (C+1)'($signed(corner_x[k]));
         wy1_in[k] = (C+1)'($signed(start_y)) - (C+1)'($signed(corner_y[k]));
      end
   end

   always_comb begin
      logic signed [SW-1:0] a, d;
      for (int k = 0; k < NUM_EDGES; k++) begin
         a = (nw3_ff[k] < 0) ? -nw3_ff[k] : nw3_ff[k];
         d = (nd3_ff[k] < 0) ? -nd3_ff[k] : nd3_ff[k];
         an4_in[k]  = a[MW-1:0];
         ad4_in[k]  = d[MW-1:0];
         neg4_in[k] = (nw3_ff[k] > 0) != (nd3_ff[k] < 0);
         sat4_in[k] = {2'b00, a[MW-1:0]} >= {d[MW-1:0], 2'b00};
         ent4_in[k] = nd3_ff[k] > 0;
         lev4_in[k] = nd3_ff[k] < 0;
         par_rej[k] = (nd3_ff[k] == 0) && (nw3_ff[k] < 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
      if (en) begin
         px1_ff <= $signed(start_x);
         py1_ff <= $signed(start_y);
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         nx1_ff <= nx1_in;
         ny1_ff <= ny1_in;
         wx1_ff <= wx1_in;
         wy1_ff <= wy1_in;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         for (int k = 0; k < NUM_EDGES; k++) begin
            mdx_ff[k] <= nx1_ff[k] * dx1_ff;
            mdy_ff[k] <= ny1_ff[k] * dy1_ff;
            mwx_ff[k] <= nx1_ff[k] * wx1_ff[k];
            mwy_ff[k] <= ny1_ff[k] * wy1_ff[k];
            nd3_ff[k] <= SW'(mdx_ff[k]) + SW'(mdy_ff[k]);
            nw3_ff[k] <= SW'(mwx_ff[k]) + SW'(mwy_ff[k]);
         end
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         px4_ff  <= px3_ff;
         py4_ff  <= py3_ff;
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
         an4_ff  <= an4_in;
         ad4_ff  <= ad4_in;
         neg4_ff <= neg4_in;
         sat4_ff <= sat4_in;
         ent4_ff <= ent4_in;
         lev4_ff <= lev4_in;
         rej4_ff <= |par_rej;
      end
   end

   assign out_valid = v_ff[3];
   assign num_mag   = an4_ff;
   assign den_mag   = ad4_ff;
   assign neg       = neg4_ff;
   assign sat       = sat4_ff;
   assign entry     = ent4_ff;
   assign leave     = lev4_ff;
   assign rej       = rej4_ff;
   assign px        = px4_ff;
   assign py        = py4_ff;
   assign dx        = dx4_ff;
   assign dy        = dy4_ff;

endmodule

FILE: hdl/cwlc_div.sv
//------------------------------------------------------------------------------
// cwlc_div
// Pipelined restoring divider, one quotient bit per stage, four lanes.
// Side payload travels alongside.
//------------------------------------------------------------------------------
module cwlc_div #(
   parameter int COORD_BITS  = 12,
   parameter int T_FRAC_BITS = 16,
   parameter int PAY_BITS    = 63
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              en,
   input  logic                                              in_valid,
   input  logic [cwlc_pkg::NUM_EDGES-1:0][2*COORD_BITS+1:0]  num_mag,
   input  logic [cwlc_pkg::NUM_EDGES-1:0][2*COORD_BITS+1:0]  den_mag,
   input  logic [cwlc_pkg::NUM_EDGES-1:0]                    sat_i,
   input  logic [PAY_BITS-1:0]                               pay_i,
   output logic                                              out_valid,
   output logic [cwlc_pkg::NUM_EDGES-1:0][T_FRAC_BITS+1:0]   quot,
   output logic [cwlc_pkg::NUM_EDGES-1:0]                    sat_o,
   output logic [PAY_BITS-1:0]                               pay_o
);
   import cwlc_pkg::*;

   localparam int MW = 2 * COORD_BITS + 2;
   localparam int RW = MW + 2;
   localparam int QW = T_FRAC_BITS + 2;
   localparam int N  = QW;

   logic [N-1:0] v_ff;
   logic [NUM_EDGES-1:0][RW-1:0] r_ff [N];
   logic [NUM_EDGES-1:0][RW-1:0] d_ff [N];
   logic [NUM_EDGES-1:0][QW-1:0] q_ff [N];
   logic [NUM_EDGES-1:0]         s_ff [N];
   logic [PAY_BITS-1:0]          p_ff [N];
   logic [NUM_EDGES-1:0][RW-1:0] r_in [N];
   logic [NUM_EDGES-1:0][RW-1:0] d_in [N];
   logic [NUM_EDGES-1:0][QW-1:0] q_in [N];
   logic [NUM_EDGES-1:0]         s_in [N];
   logic [PAY_BITS-1:0]          p_in [N];

   always_comb begin
      logic [NUM_EDGES-1:0][RW-1:0] rs, ds;
      logic [NUM_EDGES-1:0][QW-1:0] qs;
      logic b;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
               rs[k] = {2'b00, num_mag[k]};
               ds[k] = {1'b0, den_mag[k], 1'b0};
            end
            qs      = '0;
            s_in[i] = sat_i;
            p_in[i] = pay_i;
         end else begin
            rs      = r_ff[i-1];
            ds      = d_ff[i-1];
            qs      = q_ff[i-1];
            s_in[i] = s_ff[i-1];
            p_in[i] = p_ff[i-1];
         end
         for (int k = 0; k < NUM_EDGES; k++) begin
            b            = rs[k] >= ds[k];
            r_in[i][k]   = (b ? rs[k] - ds[k] : rs[k]) << 1;
            q_in[i][k]   = {qs[k][QW-2:0], b};
         end
         d_in[i] = ds;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N-2:0], in_valid};
      end
      if (en) begin
         r_ff <= r_in;
         d_ff <= d_in;
         q_ff <= q_in;
         s_ff <= s_in;
         p_ff <= p_in;
      end
   end

   assign out_valid = v_ff[N-1];
   assign quot      = q_ff[N-1];
   assign sat_o     = s_ff[N-1];
   assign pay_o     = p_ff[N-1];

endmodule

FILE: hdl/cwlc_back.sv
//------------------------------------------------------------------------------
// cwlc_back
// Parameter selection, reject test, endpoint interpolation and a two-entry
// output buffer that drives the response channel.
//------------------------------------------------------------------------------
module cwlc_back #(
   parameter int COORD_BITS  = 12,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   input  logic [cwlc_pkg::NUM_EDGES-1:0][T_FRAC_BITS+1:0]  quot,
   input  logic [cwlc_pkg::NUM_EDGES-1:0]                   sat,
   input  logic [cwlc_pkg::NUM_EDGES-1:0]                   neg,
   input  logic [cwlc_pkg::NUM_EDGES-1:0]                   entry,
   input  logic [cwlc_pkg::NUM_EDGES-1:0]                   leave,
   input  logic                                             rej,
   input  logic [COORD_BITS-1:0]                            px,
   input  logic [COORD_BITS-1:0]                            py,
   input  logic [COORD_BITS:0]                              dx,
   input  logic [COORD_BITS:0]                              dy,
   output logic                                             en,
   output logic                                             rsp_tvalid,
   input  logic                                             rsp_tready,
   output logic                                             visible,
   output logic [4*COORD_BITS-1:0]                          coords
);
   import cwlc_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = T_FRAC_BITS;
   localparam int QW = F + 2;
   localparam int TW = F + 3;
   localparam int MP = TW + C + 1;
   localparam int VW = F + C + 5;
   localparam logic [QW-1:0]        LIM  = QW'(1) << (F + 1);
   localparam logic signed [TW-1:0] ONE  = TW'(1) <<< F;
   localparam logic signed [VW-1:0] HALF = VW'(1) <<< (F - 1);

   logic [2:0] v_ff;

   // stage 1
   logic signed [TW-1:0] t1_ff [NUM_EDGES];
   logic signed [TW-1:0] t1_in [NUM_EDGES];
   logic [NUM_EDGES-1:0] ent1_ff, lev1_ff;
   logic                 rej1_ff;
   logic signed [C-1:0]  px1_ff, py1_ff;
   logic signed [C:0]    dx1_ff, dy1_ff;
   // stage 2
   logic signed [TW-1:0] te2_ff, tl2_ff, te2_in, tl2_in;
   logic                 rej2_ff;
   logic signed [C-1:0]  px2_ff, py2_ff;
   logic signed [C:0]    dx2_ff, dy2_ff;
   // stage 3
   logic signed [MP-1:0] ex3_ff, ey3_ff, lx3_ff, ly3_ff;
   logic                 rej3_ff;
   logic signed [C-1:0]  px3_ff, py3_ff;

   // output buffer
   logic [4*C:0] buf_ff [2];
   logic [4*C:0] res_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   always_comb begin
      logic [QW-1:0] qm;
      for (int k = 0; k < NUM_EDGES; k++) begin
         qm       = (sat[k] || quot[k] > LIM) ? LIM : quot[k];
         t1_in[k] = neg[k] ? -$signed(TW'(qm)) : $signed(TW'(qm));
      end
   end

   always_comb begin
      te2_in = '0;
      tl2_in = ONE;
      for (int k = 0; k < NUM_EDGES; k++) begin
         if (ent1_ff[k] && t1_ff[k] > te2_in) begin
            te2_in = t1_ff[k];
         end
         if (lev1_ff[k] && t1_ff[k] < tl2_in) begin
            tl2_in = t1_ff[k];
         end
      end
   end

   function automatic logic [C-1:0] lerp(input logic signed [C-1:0] p,
                                         input logic signed [MP-1:0] m);
      logic signed [VW-1:0] v;
      v = (VW'(p) <<< F) + VW'(m) + HALF;
      return v[F+C-1:F];
   endfunction

   always_comb begin
      if (rej3_ff) begin
         res_in = '0;
      end else begin
         res_in = {1'b1, lerp(py3_ff, ly3_ff), lerp(px3_ff, lx3_ff),
                   lerp(py3_ff, ey3_ff), lerp(px3_ff, ex3_ff)};
      end
   end

   assign en   = (cnt_ff != 2'd2) || rsp_tready;
   assign push = en && v_ff[2];
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (en) begin
            v_ff <= {v_ff[1:0], in_valid};
         end
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (en) begin
         t1_ff   <= t1_in;
         ent1_ff <= entry;
         lev1_ff <= leave;
         rej1_ff <= rej;
         px1_ff  <= $signed(px);
         py1_ff  <= $signed(py);
         dx1_ff  <= $signed(dx);
         dy1_ff  <= $signed(dy);
         te2_ff  <= te2_in;
         tl2_ff  <= tl2_in;
         rej2_ff <= rej1_ff;
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         rej3_ff <= rej2_ff || (te2_ff > tl2_ff);
         ex3_ff  <= te2_ff * dx2_ff;
         ey3_ff  <= te2_ff * dy2_ff;
         lx3_ff  <= tl2_ff * dx2_ff;
         ly3_ff  <= tl2_ff * dy2_ff;
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= res_in;
      end
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign visible    = buf_ff[rd_ptr_ff][4*C];
   assign coords     = buf_ff[rd_ptr_ff][4*C-1:0];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("output buffer count out of range");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push && cnt_ff == 2'd2) |-> pop)
      else $error("output buffer overrun");
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !visible) |-> (coords == '0))
      else $error("rejected response carries coordinates");

endmodule

FILE: tb/sv/convex_window_line_clipper_core_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// convex_window_line_clipper_core_test
// Self-checking bench for the line clipper. Segments are streamed against
// several window settings (default, full range, degenerate, counterclockwise)
// and every response is compared with a built-in clipping predictor.
//------------------------------------------------------------------------------
module convex_window_line_clipper_core_test;
   import cwlc_pkg::*;

   localparam int CB        = 12;
   localparam int TF        = 16;
   localparam int DW        = ((4*CB+7)/8)*8;
   localparam int LATENCY   = TF + 10;
   localparam int MAX_CYC   = 400000;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      logic      visible;
      coord_type ey, ex, sy, sx;
   } clip_type;

   logic            clock = 0;
   logic            reset = 1;
   logic            req_tvalid = 0;
   logic            req_tready;
   logic [DW-1:0]   req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 0;
   logic [DW-1:0]   rsp_tdata;
   logic            rsp_tuser;
   logic            csr_wr_en = 0;
   logic [REG_IDX_BITS-1:0] csr_index = '0;
   logic [CB-1:0]   csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycles = 0;
   int n_seg = 0;

   always #2 clock = ~clock;

   convex_window_line_clipper_core u_top (.*);

   //------------------------------------------------------------------------
   class clip_scoreboard;
      coord_type corner [NUM_REGS];
      clip_type  pending [$];
      int        errors;
      int        n_visible;
      int        n_checked;

      function void reset_window();
         foreach (corner[i]) corner[i] = coord_type'(CORNER_RESET[i]);
      endfunction

      function longint quotient(longint num, longint den);
         longint an, ad, q;
         bit neg;
         neg = (num < 0) != (den < 0);
         an  = num < 0 ? -num : num;
         ad  = den < 0 ? -den : den;
         q   = (an <<< TF) / ad;
         if (q > (longint'(2) <<< TF)) q = longint'(2) <<< TF;
         return neg ? -q : q;
      endfunction

      function coord_type interp(longint p, longint t, longint d);
         longint v;
         v = (p <<< TF) + t * d + (longint'(1) <<< (TF-1));
         return coord_type'(v >>> TF);
      endfunction

      function void note_request(logic [DW-1:0] data);
         longint px, py, dx, dy, sx, sy, ex, ey, nx, ny, nd, nw, t, te, tl;
         bit rej;
         int nk;
         clip_type r;
         px = coord_type'(data[CB-1:0]);
         py = coord_type'(data[2*CB-1:CB]);
         dx = longint'(coord_type'(data[3*CB-1:2*CB])) - px;
         dy = longint'(coord_type'(data[4*CB-1:3*CB])) - py;
         te = 0;
         tl = longint'(1) <<< TF;
         rej = 0;
         for (int k = 0; k < NUM_EDGES; k++) begin
            nk = (k + 1) % NUM_EDGES;
            sx = corner[2*k];  sy = corner[2*k+1];
            ex = corner[2*nk]; ey = corner[2*nk+1];
            nx = ey - sy;
            ny = sx - ex;
            nd = nx * dx + ny * dy;
            nw = nx * (px - sx) + ny * (py - sy);
            if (nd != 0) begin
               t = quotient(-nw, nd);
               if (nd > 0) begin
                  if (t > te) te = t;
               end else if (t < tl) begin
                  tl = t;
               end
            end else if (nw < 0) begin
               rej = 1;
            end
         end
         if (te > tl) rej = 1;
         r = '0;
         if (!rej) begin
            r.visible = 1;
            r.sx = interp(px, te, dx);
            r.sy = interp(py, te, dy);
            r.ex = interp(px, tl, dx);
            r.ey = interp(py, tl, dy);
            n_visible++;
         end
         pending = {pending, r};
      endfunction

      function void check_response(logic vis, logic [DW-1:0] data);
         clip_type got, exp_r;
         got = {vis, coord_type'(data[4*CB-1:3*CB]), coord_type'(data[3*CB-1:2*CB]),
                coord_type'(data[2*CB-1:CB]), coord_type'(data[CB-1:0])};
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         n_checked++;
         if (got.visible !== exp_r.visible || got.sx !== exp_r.sx ||
             got.sy !== exp_r.sy || got.ex !== exp_r.ex || got.ey !== exp_r.ey) begin
            $display("%0t: expected %0d (%0d,%0d)-(%0d,%0d) actual %0d (%0d,%0d)-(%0d,%0d)",
                     $time, exp_r.visible, exp_r.sx, exp_r.sy, exp_r.ex, exp_r.ey,
                     got.visible, got.sx, got.sy, got.ex, got.ey);
            errors++;
         end
      endfunction
   endclass

   clip_scoreboard sb;

   // response side: sample at rising edge, drive ready at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYC) begin
         $display("convex_window_line_clipper_core verification failed");
         $finish;
      end
   end

   task automatic send_segment(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
      sb.note_request({ey, ex, sy, sx});
      n_seg++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_corner(int idx, coord_type val);
      csr_wr_en <= 1;
      csr_index <= idx[REG_IDX_BITS-1:0];
      csr_wdata <= val;
      @(negedge clock);
      sb.corner[idx] = val;
   endtask

   task automatic set_window(int x0, int y0, int x1, int y1,
                             int x2, int y2, int x3, int y3);
      int v [NUM_REGS];
      v = '{x0, y0, x1, y1, x2, y2, x3, y3};
      for (int i = 0; i < NUM_REGS; i++) write_corner(i, coord_type'(v[i]));
      csr_wr_en <= 0;
   endtask

   function automatic coord_type rnd_coord();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type near(int c, int spread);
      int v;
      v = c + $urandom_range(2*spread) - spread;
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      return coord_type'(v);
   endfunction

   task automatic random_segments(int n, int lo, int hi);
      int mid;
      mid = (lo + hi) / 2;
      repeat (n) begin
         case ($urandom_range(3))
            0: send_segment(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            1: begin
               coord_type x, y;
               x = near(mid, hi - lo + 50);
               y = near(mid, hi - lo + 50);
               send_segment(x, y, x, y);
            end
            default: send_segment(near(mid, hi - lo), near(mid, hi - lo),
                                  near(mid, hi - lo), near(mid, hi - lo));
         endcase
      end
   endtask

   task automatic run_phase(int idle, int stall, int n, int lo, int hi);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      random_segments(n, lo, hi);
   endtask

   initial begin
      sb = new();
      sb.reset_window();
      repeat (3) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: default window 100..300
      send_segment(0, 200, 400, 200);          // crosses both sides
      send_segment(150, 150, 250, 250);        // fully inside
      send_segment(0, 0, 50, 50);              // outside
      send_segment(200, 200, 200, 200);        // point inside
      send_segment(400, 400, 400, 400);        // point outside
      send_segment(100, 50, 100, 400);         // along an edge
      send_segment(-2048, -2048, 2047, 2047);  // extreme diagonal
      send_segment(2047, -2048, -2048, 2047);
      send_segment(-1, -1, -1, -1);
      send_segment(250, 0, 250, 350);
      send_segment(201, 201, 202, 1);          // odd slopes for rounding
      send_segment(99, 300, 301, 299);
      drain();

      // full-range window and degenerate / counterclockwise windows
      set_window(-2048, -2048, -2048, 2047, 2047, 2047, 2047, -2048);
      send_segment(-2048, 0, 2047, 0);
      send_segment(2047, 2047, -2048, -2048);
      send_segment(-5, 7, 3, -1);
      drain();
      set_window(0, 0, 0, 0, 0, 0, 0, 0);
      send_segment(10, 10, -10, -10);
      send_segment(0, 0, 0, 0);
      drain();
      set_window(100, 100, 300, 100, 300, 300, 100, 300);
      send_segment(0, 200, 400, 200);
      send_segment(200, 200, 200, 200);
      drain();

      // random phases on assorted windows
      set_window(100, 100, 100, 300, 300, 300, 300, 100);
      run_phase(0, 0, 150, 100, 300);
      run_phase(54, 0, 120, 100, 300);
      drain();  // sender holds off until all responses are in
      set_window(-500, 0, 0, 500, 500, 0, 0, -500);
      run_phase(0, 54, 150, -500, 500);
      run_phase(37, 37, 100, -500, 500);
      drain();
      set_window(-2048, -2048, -2048, 2047, 2047, 2047, 2047, -2048);
      run_phase(37, 37, 80, -2048, 2047);
      drain();
      set_window(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      run_phase(54, 54, 80, -600, 600);
      drain();
      set_window(-20, -20, -20, 30, 30, 30, 30, -20);
      run_phase(0, 0, 100, -20, 30);
      drain();
      set_window(100, 100, 100, 300, 300, 300, 300, 100);
      run_phase(37, 37, 100, 100, 300);
      drain();

      $display("Clipped %0d segments over seven windows, %0d of them visible.",
               n_seg, sb.n_visible);
      $display("Responses checked: %0d, mismatches: %0d", sb.n_checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("convex_window_line_clipper_core verification clean");
      else
         $display("convex_window_line_clipper_core verification failed");
      $finish;
   end

endmodule

FILE: convex_window_line_clipper_core.f
hdl/cwlc_pkg.sv
hdl/cwlc_front.sv
hdl/cwlc_div.sv
hdl/cwlc_back.sv
hdl/convex_window_line_clipper_core.sv
tb/sv/convex_window_line_clipper_core_test.sv
